/* rtl/mae_pkg.sv */
package mae_pkg;

  localparam int S_TDATA_W = 40;  // elem_index, elem_value, zero pad
  localparam int M_TDATA_W = 40;  // result_value, result_index, zero pad
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_SCALE
  } op_e;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_START
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COLS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 3'd5;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } st_e;

  // control that travels alongside one store read through the pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic lastk;
    logic zero;
    logic oob_a;
    logic oob_b;
  } ctl_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    if (&v[63:31] || ~|v[63:31]) begin
      return v[31:0];
    end
    return v[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] == v[31]) begin
      return v[31:0];
    end
    return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

endpackage

/* rtl/mae_ram.sv */
module mae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/matrix_arithmetic_engine.sv */
// Fixed-point matrix engine. Load beats (tuser = load A / load B) write one
// Q16.16 element per cycle into the A or B store. A start beat then streams the
// result matrix out in row-major order, tlast on the final element, tuser set
// when the configured shapes were compatible (otherwise every value is zero).
// Each result element takes K reads of each store, where K is the inner dimension
// (a_cols, at least 1) in multiply mode and 1 in add, subtract and scale mode or
// on a shape mismatch: one read of each store per cycle feeds a single 32x32
// multiplier, followed by shift/saturate and accumulate stages, and the next
// element starts once the current one is handed to the output register. Input
// is accepted only while no start is in progress; loads and stores never
// overlap, so no forwarding is needed. Configuration writes are taken at any
// time but must only change while the engine is idle.
module matrix_arithmetic_engine
  import mae_pkg::*;
#(
  parameter int MAX_DIM   = 8,
  parameter int MAX_ELEMS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // slave: [5:0] elem_index, [37:6] elem_value, [39:38] zero
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic [1:0]           s_axis_tuser,   // [1:0] cmd
  // master: [31:0] result_value, [37:32] result_index, [39:38] zero
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tlast,
  output logic [0:0]           m_axis_tuser,   // [0] dims_match
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int AW     = $clog2(MAX_ELEMS);
  localparam int DW     = $clog2(MAX_DIM + 1);
  localparam int PW_POS = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int PW     = (PW_POS > 1) ? PW_POS : 1;

  function automatic logic [DW-1:0] clamp_dim(input logic [3:0] d);
    if (32'(d) > MAX_DIM) begin
      return DW'(MAX_DIM);
    end
    return DW'(d);
  endfunction

  // configuration
  op_e                op_mode_q;
  logic [3:0]         a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic signed [31:0] scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q <= OP_MUL;
      a_rows_q  <= 4'd1;
      a_cols_q  <= 4'd1;
      b_rows_q  <= 4'd1;
      b_cols_q  <= 4'd1;
      scale_q   <= Q_ONE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OP_MODE: op_mode_q <= op_e'(cfg_data_i[1:0]);
        CFG_A_ROWS:  a_rows_q  <= cfg_data_i[3:0];
        CFG_A_COLS:  a_cols_q  <= cfg_data_i[3:0];
        CFG_B_ROWS:  b_rows_q  <= cfg_data_i[3:0];
        CFG_B_COLS:  b_cols_q  <= cfg_data_i[3:0];
        CFG_SCALE:   scale_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input beat decode
  logic [5:0]  in_idx;
  logic [31:0] in_val;
  logic        in_acc, start_acc, we_a, we_b, idx_ok;

  assign in_idx    = s_axis_tdata[5:0];
  assign in_val    = s_axis_tdata[37:6];
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign idx_ok    = 32'(in_idx) < MAX_ELEMS;
  assign we_a      = in_acc && (s_axis_tuser == CMD_LOAD_A) && idx_ok;
  assign we_b      = in_acc && (s_axis_tuser == CMD_LOAD_B) && idx_ok;
  assign start_acc = in_acc && (s_axis_tuser == CMD_START);

  // shape decode for a start beat
  logic [DW-1:0] ar, ac, br, bc, cols_s, klim_s;
  logic          mul_s, match_s, zero_s, empty_s;

  always_comb begin
    ar      = clamp_dim(a_rows_q);
    ac      = clamp_dim(a_cols_q);
    br      = clamp_dim(b_rows_q);
    bc      = clamp_dim(b_cols_q);
    mul_s   = (op_mode_q == OP_MUL);
    cols_s  = mul_s ? bc : ac;
    match_s = mul_s ? (ac == br) : ((op_mode_q == OP_SCALE) || (ar == br && ac == bc));
    zero_s  = !match_s || (mul_s && ac == '0);
    klim_s  = (mul_s && !zero_s) ? ac : DW'(1);
    empty_s = (ar == '0) || (cols_s == '0);
  end

  // sequencer state
  st_e           state_q, state_d;
  logic [DW-1:0] rows_q, cols_q, ac_q, bc_q, klim_q;
  logic [DW-1:0] i_q, j_q, k_q;
  logic [PW-1:0] a_base_q, a_pos_q, b_pos_q, out_pos_q;
  logic          match_q, zero_q, res_rdy_q, m_valid_q;
  logic          issue, lastk, push, last_elem, mul_mode;

  assign mul_mode  = (op_mode_q == OP_MUL);
  assign lastk     = (k_q == DW'(klim_q - DW'(1)));
  assign last_elem = (i_q == DW'(rows_q - DW'(1))) && (j_q == DW'(cols_q - DW'(1)));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start_acc && !empty_s) state_d = ST_ISSUE;
      ST_ISSUE: if (lastk) state_d = ST_DRAIN;
      ST_DRAIN: if (push) state_d = last_elem ? ST_IDLE : ST_ISSUE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    issue         = (state_q == ST_ISSUE);
    push          = (state_q == ST_DRAIN) && res_rdy_q && (!m_valid_q || m_axis_tready);
  end

  // position of the next element
  logic [DW-1:0] j_nx, i_nx;
  logic [PW-1:0] a_base_nx, out_pos_nx;

  always_comb begin
    out_pos_nx = out_pos_q + PW'(1);
    if (j_q == DW'(cols_q - DW'(1))) begin
      j_nx      = '0;
      i_nx      = i_q + DW'(1);
      a_base_nx = a_base_q + PW'(ac_q);
    end else begin
      j_nx      = j_q + DW'(1);
      i_nx      = i_q;
      a_base_nx = a_base_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rows_q    <= '0;
      cols_q    <= '0;
      ac_q      <= '0;
      bc_q      <= '0;
      klim_q    <= '0;
      match_q   <= 1'b0;
      zero_q    <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      a_base_q  <= '0;
      a_pos_q   <= '0;
      b_pos_q   <= '0;
      out_pos_q <= '0;
    end else begin
      state_q <= state_d;
      if (start_acc) begin
        rows_q    <= ar;
        cols_q    <= cols_s;
        ac_q      <= ac;
        bc_q      <= bc;
        klim_q    <= klim_s;
        match_q   <= match_s;
        zero_q    <= zero_s;
        i_q       <= '0;
        j_q       <= '0;
        k_q       <= '0;
        a_base_q  <= '0;
        a_pos_q   <= '0;
        b_pos_q   <= '0;
        out_pos_q <= '0;
      end else if (issue) begin
        k_q     <= lastk ? '0 : k_q + DW'(1);
        a_pos_q <= a_pos_q + PW'(1);
        b_pos_q <= b_pos_q + PW'(bc_q);
      end else if (push) begin
        i_q       <= i_nx;
        j_q       <= j_nx;
        a_base_q  <= a_base_nx;
        out_pos_q <= out_pos_nx;
        a_pos_q   <= mul_mode ? a_base_nx : out_pos_nx;
        b_pos_q   <= mul_mode ? PW'(j_nx) : out_pos_nx;
      end
    end
  end

  // stores
  logic [31:0] rdata_a, rdata_b;

  mae_ram #(.WIDTH(32), .DEPTH(MAX_ELEMS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (AW'(in_idx)),
    .wdata_i (in_val),
    .raddr_i (AW'(a_pos_q)),
    .rdata_o (rdata_a)
  );

  mae_ram #(.WIDTH(32), .DEPTH(MAX_ELEMS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (AW'(in_idx)),
    .wdata_i (in_val),
    .raddr_i (AW'(b_pos_q)),
    .rdata_o (rdata_b)
  );

  // pipeline: read -> multiply/add -> shift/saturate -> accumulate
  ctl_t s1_q, s2_q, s3_q, iss_ctl;

  always_comb begin
    iss_ctl.valid = issue;
    iss_ctl.first = (k_q == '0);
    iss_ctl.lastk = lastk;
    iss_ctl.zero  = zero_q;
    iss_ctl.oob_a = 32'(a_pos_q) >= MAX_ELEMS;
    iss_ctl.oob_b = 32'(b_pos_q) >= MAX_ELEMS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= '0;
      s2_q      <= '0;
      s3_q      <= '0;
      res_rdy_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      s1_q <= iss_ctl;
      s2_q <= s1_q;
      s3_q <= s2_q;
      if (push) begin
        res_rdy_q <= 1'b0;
      end else if (s3_q.valid && s3_q.lastk) begin
        res_rdy_q <= 1'b1;
      end
      if (push) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  logic signed [31:0] a_op, b_op, m_op, v_d, v_q, acc_q;
  logic signed [63:0] prod_d, prod_q;
  logic signed [32:0] sum_d, sum_q;

  always_comb begin
    a_op   = s1_q.oob_a ? 32'sd0 : $signed(rdata_a);
    b_op   = s1_q.oob_b ? 32'sd0 : $signed(rdata_b);
    m_op   = (op_mode_q == OP_SCALE) ? scale_q : b_op;
    prod_d = 64'(a_op) * 64'(m_op);
    sum_d  = (op_mode_q == OP_SUB) ? 33'(a_op) - 33'(b_op) : 33'(a_op) + 33'(b_op);
  end

  always_comb begin
    if (s2_q.zero) begin
      v_d = 32'sd0;
    end else if (op_mode_q == OP_MUL || op_mode_q == OP_SCALE) begin
      v_d = sat64(prod_q >>> FRAC_BITS);   // arithmetic shift floors
    end else begin
      v_d = sat33(sum_q);
    end
  end

  logic [M_TDATA_W-1:0] m_data_q;
  logic                 m_last_q, m_match_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
    v_q    <= v_d;
    if (s3_q.valid) begin
      acc_q <= s3_q.first ? v_q : sat33(33'(acc_q) + 33'(v_q));
    end
    if (push) begin
      m_data_q  <= {2'b00, 6'(out_pos_q), acc_q};
      m_last_q  <= last_elem;
      m_match_q <= match_q;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tlast    = m_last_q;
  assign m_axis_tuser[0] = m_match_q;

endmodule

/* rtl/mae_checker.sv */
module mae_checker
  import mae_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tlast,
  input logic [0:0]           m_axis_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // shape mismatch gives zero values
  a_mismatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'd0)
    else $error("nonzero value on mismatched shape");

  // mid-matrix the engine is still busy and takes no input
  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input accepted while result matrix incomplete");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:38] == 2'b00)
    else $error("pad bits of result beat set");

endmodule

bind matrix_arithmetic_engine mae_checker u_mae_checker (.*);
